// ===== hdl/sha1_byte_stream_hasher_top_macros.svh =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher - assertion macros
// Clocked assertion wrappers for the hasher controller.
// ----------------------------------------------------------------------------
`ifndef SHA1_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_TOP_MACROS_SVH

// Checked on every rising edge outside reset.
`define SHA1BS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SHA1BS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/sha1bs_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher - package
// Constants, state and command types and round functions.
// ----------------------------------------------------------------------------
package sha1bs_pkg;

  localparam int BLOCK_COUNT_BITS_DEF = 23;

  localparam int WORD_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int POS_W     = 6;
  localparam int ROUND_W   = 7;
  localparam int WIDX_W    = 3;
  localparam int NUM_WORDS = 5;
  localparam int WIN_DEPTH = 16;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
  localparam logic [WIDX_W-1:0]  LAST_WORD  = 3'd4;
  localparam logic [POS_W-1:0]   POS_LAST    = 6'd63;
  localparam logic [POS_W-1:0]   POS_PAD_END = 6'd55;
  localparam logic [POS_W-1:0]   POS_LEN_LO  = 6'd60;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  localparam logic [WORD_W-1:0] H_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_HADD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic               shift_en;
    byte_src_t          src;
    logic               len_capture;
    logic               round_start;
    logic               round_en;
    logic [ROUND_W-1:0] round_idx;
    logic               hash_add;
    logic               block_done;
    logic               msg_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             overflow;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] round_f(
    input logic [ROUND_W-1:0] idx,
    input logic [WORD_W-1:0]  b,
    input logic [WORD_W-1:0]  c,
    input logic [WORD_W-1:0]  d
  );
    logic [WORD_W-1:0] f;
    priority if (idx < 7'd20) begin
      f = d ^ (b & (c ^ d));
    end else if (idx < 7'd40) begin
      f = b ^ c ^ d;
    end else if (idx < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] idx);
    logic [WORD_W-1:0] k;
    priority if (idx < 7'd20) begin
      k = K0;
    end else if (idx < 7'd40) begin
      k = K1;
    end else if (idx < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// ===== hdl/sha1bs_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher - datapath
// Block window, round registers, chaining words, byte and block counters.
// ----------------------------------------------------------------------------
module sha1bs_datapath #(
  parameter int BLOCK_COUNT_BITS = sha1bs_pkg::BLOCK_COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sha1bs_pkg::dp_cmd_t                   cmd,
  input  logic [sha1bs_pkg::BYTE_W-1:0]         data_byte,
  input  logic [sha1bs_pkg::WIDX_W-1:0]         word_sel,
  output sha1bs_pkg::dp_status_t                status,
  output logic [sha1bs_pkg::WORD_W-1:0]         digest
);

  localparam int LEN_FULL_W = BLOCK_COUNT_BITS + sha1bs_pkg::POS_W + 3;

  // message window: word 0 is the oldest, bytes enter at the low end of the last word
  logic [sha1bs_pkg::WORD_W-1:0] w_r [sha1bs_pkg::WIN_DEPTH];
  logic [sha1bs_pkg::WORD_W-1:0] a_r, b_r, c_r, d_r, e_r;
  logic [sha1bs_pkg::WORD_W-1:0] h_r [sha1bs_pkg::NUM_WORDS];
  logic [sha1bs_pkg::POS_W-1:0]  pos_r;
  logic [BLOCK_COUNT_BITS-1:0]   blk_cnt_r;
  logic                          ovf_r;
  logic [sha1bs_pkg::WORD_W-1:0] len_r;

  logic [sha1bs_pkg::BYTE_W-1:0] byte_in;
  logic [sha1bs_pkg::WORD_W-1:0] sched_new;
  logic [sha1bs_pkg::WORD_W-1:0] t_sum;
  logic [LEN_FULL_W-1:0]         len_full;
  logic [63:0]                   len_ext;
  logic [BLOCK_COUNT_BITS:0]     cnt_inc;

  always_comb begin
    byte_in = '0;
    unique case (cmd.src)
      sha1bs_pkg::SRC_DATA: byte_in = data_byte;
      sha1bs_pkg::SRC_PAD:  byte_in = sha1bs_pkg::PAD_BYTE;
      sha1bs_pkg::SRC_ZERO: byte_in = '0;
      sha1bs_pkg::SRC_LEN: begin
        if (pos_r < sha1bs_pkg::POS_LEN_LO) begin
          byte_in = '0;     // upper length word stays zero
        end else begin
          unique case (pos_r[1:0])
            2'd0: byte_in = len_r[31:24];
            2'd1: byte_in = len_r[23:16];
            2'd2: byte_in = len_r[15:8];
            2'd3: byte_in = len_r[7:0];
            default: byte_in = '0;
          endcase
        end
      end
      default: byte_in = '0;
    endcase
  end

  assign sched_new = {w_r[0][30:0], w_r[0][31]} ^ {w_r[2][30:0], w_r[2][31]}
                   ^ {w_r[8][30:0], w_r[8][31]} ^ {w_r[13][30:0], w_r[13][31]};

  assign t_sum = {a_r[26:0], a_r[31:27]}
               + sha1bs_pkg::round_f(cmd.round_idx, b_r, c_r, d_r)
               + e_r + sha1bs_pkg::round_k(cmd.round_idx) + w_r[0];

  assign len_full = {blk_cnt_r, pos_r, 3'b000};
  assign len_ext  = 64'(len_full);
  assign cnt_inc  = {1'b0, blk_cnt_r} + (BLOCK_COUNT_BITS + 1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      for (int i = 0; i < sha1bs_pkg::WIN_DEPTH - 1; i++) begin
        w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_r[sha1bs_pkg::WIN_DEPTH-1] <= {w_r[sha1bs_pkg::WIN_DEPTH-1][23:0], byte_in};
    end else if (cmd.round_en) begin
      for (int i = 0; i < sha1bs_pkg::WIN_DEPTH - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[sha1bs_pkg::WIN_DEPTH-1] <= sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_en) begin
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_capture) begin
      len_r <= len_ext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.msg_clear) begin
      for (int i = 0; i < sha1bs_pkg::NUM_WORDS; i++) begin
        h_r[i] <= sha1bs_pkg::H_INIT[i];
      end
      pos_r     <= '0;
      blk_cnt_r <= '0;
      ovf_r     <= 1'b0;
    end else begin
      if (cmd.hash_add) begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
      end
      if (cmd.shift_en) begin
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.block_done) begin
        blk_cnt_r <= cnt_inc[BLOCK_COUNT_BITS-1:0];
        if (cnt_inc[BLOCK_COUNT_BITS]) begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    digest = h_r[0];
    unique case (word_sel)
      3'd0: digest = h_r[0];
      3'd1: digest = h_r[1];
      3'd2: digest = h_r[2];
      3'd3: digest = h_r[3];
      3'd4: digest = h_r[4];
      default: digest = h_r[0];
    endcase
  end

  assign status.pos      = pos_r;
  assign status.overflow = ovf_r;

endmodule

// ===== hdl/sha1bs_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher - controller
// Sequences byte intake, padding, 80 rounds, feed-forward and digest output.
// ----------------------------------------------------------------------------
`include "sha1_byte_stream_hasher_top_macros.svh"

module sha1bs_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_action,
  output logic                              in_stall,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  sha1bs_pkg::dp_status_t            status,
  output sha1bs_pkg::dp_cmd_t               cmd,
  output logic [sha1bs_pkg::WIDX_W-1:0]     word_idx
);

  sha1bs_pkg::state_t                state_r, state_nxt;
  logic [sha1bs_pkg::ROUND_W-1:0]    round_cnt_r, round_cnt_nxt;
  logic [sha1bs_pkg::WIDX_W-1:0]     word_idx_r, word_idx_nxt;
  logic                              final_r, final_nxt;
  logic                              pad_r, pad_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1bs_pkg::ST_IDLE;
      round_cnt_r <= '0;
      word_idx_r  <= '0;
      final_r     <= 1'b0;
      pad_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_cnt_r <= round_cnt_nxt;
      word_idx_r  <= word_idx_nxt;
      final_r     <= final_nxt;
      pad_r       <= pad_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    round_cnt_nxt = round_cnt_r;
    word_idx_nxt  = word_idx_r;
    final_nxt     = final_r;
    pad_nxt       = pad_r;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.src       = sha1bs_pkg::SRC_DATA;
    cmd.round_idx = round_cnt_r;

    unique case (state_r)
      sha1bs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == sha1bs_pkg::ACT_FINISH) begin
            cmd.shift_en    = 1'b1;
            cmd.src         = sha1bs_pkg::SRC_PAD;
            cmd.len_capture = 1'b1;
            pad_nxt         = 1'b1;
            if (status.pos == sha1bs_pkg::POS_LAST) begin
              cmd.round_start = 1'b1;
              state_nxt       = sha1bs_pkg::ST_ROUND;
            end else if (status.pos == sha1bs_pkg::POS_PAD_END) begin
              state_nxt = sha1bs_pkg::ST_LEN;
            end else begin
              state_nxt = sha1bs_pkg::ST_PAD;
            end
          end else if (!status.overflow) begin
            cmd.shift_en = 1'b1;
            cmd.src      = sha1bs_pkg::SRC_DATA;
            if (status.pos == sha1bs_pkg::POS_LAST) begin
              cmd.round_start = 1'b1;
              cmd.block_done  = 1'b1;
              state_nxt       = sha1bs_pkg::ST_ROUND;
            end
          end
        end
      end

      sha1bs_pkg::ST_PAD: begin
        cmd.shift_en = 1'b1;
        cmd.src      = sha1bs_pkg::SRC_ZERO;
        if (status.pos == sha1bs_pkg::POS_LAST) begin
          // 0x80 landed too late for the length: close this block first
          cmd.round_start = 1'b1;
          state_nxt       = sha1bs_pkg::ST_ROUND;
        end else if (status.pos == sha1bs_pkg::POS_PAD_END) begin
          state_nxt = sha1bs_pkg::ST_LEN;
        end
      end

      sha1bs_pkg::ST_LEN: begin
        cmd.shift_en = 1'b1;
        cmd.src      = sha1bs_pkg::SRC_LEN;
        if (status.pos == sha1bs_pkg::POS_LAST) begin
          cmd.round_start = 1'b1;
          final_nxt       = 1'b1;
          state_nxt       = sha1bs_pkg::ST_ROUND;
        end
      end

      sha1bs_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (round_cnt_r == sha1bs_pkg::LAST_ROUND) begin
          round_cnt_nxt = '0;
          state_nxt     = sha1bs_pkg::ST_HADD;
        end else begin
          round_cnt_nxt = round_cnt_r + 7'd1;
        end
      end

      sha1bs_pkg::ST_HADD: begin
        cmd.hash_add = 1'b1;
        priority if (final_r) begin
          state_nxt = sha1bs_pkg::ST_EMIT;
        end else if (pad_r) begin
          state_nxt = sha1bs_pkg::ST_PAD;
        end else begin
          state_nxt = sha1bs_pkg::ST_IDLE;
        end
      end

      sha1bs_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (word_idx_r == sha1bs_pkg::LAST_WORD) begin
            cmd.msg_clear = 1'b1;
            word_idx_nxt  = '0;
            final_nxt     = 1'b0;
            pad_nxt       = 1'b0;
            state_nxt     = sha1bs_pkg::ST_IDLE;
          end else begin
            word_idx_nxt = word_idx_r + 3'd1;
          end
        end
      end

      default: begin
        state_nxt = sha1bs_pkg::ST_IDLE;
      end
    endcase
  end

  assign word_idx = word_idx_r;

  `SHA1BS_ASSERT(a_last_word_to_idle, (out_valid && !out_stall && word_idx_r == sha1bs_pkg::LAST_WORD) |=> (state_r == sha1bs_pkg::ST_IDLE), "final digest transfer did not return to idle")
  `SHA1BS_ASSERT(a_hadd_after_rounds, (state_r == sha1bs_pkg::ST_HADD) |-> ($past(state_r) == sha1bs_pkg::ST_ROUND && $past(round_cnt_r) == sha1bs_pkg::LAST_ROUND), "feed-forward without a full round sequence")
  `SHA1BS_ASSERT(a_len_block_final, (state_r == sha1bs_pkg::ST_LEN && cmd.round_start) |=> final_r, "length block not marked final")
  `SHA1BS_ASSERT(a_word_idx_range, (state_r == sha1bs_pkg::ST_EMIT) |-> (word_idx_r <= sha1bs_pkg::LAST_WORD), "digest word index out of range")
  `SHA1BS_ASSERT(a_round_cnt_range, round_cnt_r <= sha1bs_pkg::LAST_ROUND, "round counter out of range")

endmodule

// ===== hdl/sha1_byte_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher - top level
// Byte-wide SHA-1: collects 64-byte blocks, pads on finish, emits H0..H4.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in_      to block   in_valid / in_stall    in_action, in_data_byte
//  out_     from block out_valid / out_stall  out_digest_word, out_word_number,
//                                             out_final_word, out_size_overflow
//
//  Bytes are absorbed one per cycle while in_stall is low; the 64th byte of a
//  block starts the rounds (ST_ROUND) and then the feed-forward (ST_HADD).
//  Finish shifts padding and length one byte per cycle up to the block end,
//  runs one or two compressions, then makes five digest transfers.
//  Input is stalled from the start of a compression until it ends, and from
//  a finish until its fifth digest word has been taken.
//  Reset is synchronous; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_top #(
  parameter int BLOCK_COUNT_BITS = sha1bs_pkg::BLOCK_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       out_digest_word,
  output logic [2:0]                        out_word_number,
  output logic                              out_final_word,
  output logic                              out_size_overflow
);

  sha1bs_pkg::dp_cmd_t                 cmd;
  sha1bs_pkg::dp_status_t              status;
  logic [sha1bs_pkg::WIDX_W-1:0]       word_idx;

  sha1bs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .word_idx  (word_idx)
  );

  sha1bs_datapath #(
    .BLOCK_COUNT_BITS (BLOCK_COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_data_byte),
    .word_sel  (word_idx),
    .status    (status),
    .digest    (out_digest_word)
  );

  assign out_word_number   = word_idx;
  assign out_final_word    = (word_idx == sha1bs_pkg::LAST_WORD);
  assign out_size_overflow = status.overflow;

endmodule
